FILE: rtl/acc_cpu_pkg.sv
`default_nettype none

package acc_cpu_pkg;

    localparam int MEM_WORDS_DEF = 256;
    localparam int WORD_W        = 32;
    localparam int PC_W          = 8;
    localparam int LEN_W         = 9;
    localparam int CMD_W         = 4;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0] PROG_LEN_RESET = 9'd256;
    localparam int SIGN_BIT = WORD_W - 1;

    localparam logic [CMD_W-1:0] CMD_DEC = 4'd0;
    localparam logic [CMD_W-1:0] CMD_LDA = 4'd1;
    localparam logic [CMD_W-1:0] CMD_LDB = 4'd2;
    localparam logic [CMD_W-1:0] CMD_LDI = 4'd3;
    localparam logic [CMD_W-1:0] CMD_ST  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_XCH = 4'd5;
    localparam logic [CMD_W-1:0] CMD_JMP = 4'd6;
    localparam logic [CMD_W-1:0] CMD_JZS = 4'd7;
    localparam logic [CMD_W-1:0] CMD_JVS = 4'd8;
    localparam logic [CMD_W-1:0] CMD_ADD = 4'd9;
    localparam logic [CMD_W-1:0] CMD_HLT = 4'd10;

    typedef enum logic [3:0] {
        OP_DEC,
        OP_LDA,
        OP_LDB,
        OP_LDI,
        OP_ST,
        OP_XCH,
        OP_JMP,
        OP_JZS,
        OP_JVS,
        OP_ADD,
        OP_HLT,
        OP_NOP
    } t_op_kind;

    // One classified instruction as it travels from the front to the back.
    typedef struct packed {
        t_op_kind            op;
        logic [PC_W-1:0]     addr;        // memory address, already reduced
        logic [PC_W-1:0]     target;      // raw jump target
        logic                tgt_in_mem;  // jump target lies inside memory
        logic [WORD_W-1:0]   imm;
    } t_inst;

endpackage

`default_nettype wire

FILE: rtl/acc_cpu_if.sv
`default_nettype none

interface acc_cpu_in_if;
    logic                                valid;
    logic                                ready;
    logic [acc_cpu_pkg::CMD_W-1:0]       command;
    logic [acc_cpu_pkg::WORD_W-1:0]      operand;

    modport source (output valid, command, operand, input ready);
    modport sink   (input valid, command, operand, output ready);
endinterface

interface acc_cpu_out_if;
    logic                                valid;
    logic                                ready;
    logic [acc_cpu_pkg::PC_W-1:0]        next_pc;
    logic [acc_cpu_pkg::WORD_W-1:0]      acc_a;
    logic [acc_cpu_pkg::WORD_W-1:0]      acc_b;
    logic                                overflow_flag;
    logic                                zero_flag;
    logic                                halted;

    modport source (output valid, next_pc, acc_a, acc_b, overflow_flag, zero_flag, halted,
                    input ready);
    modport sink   (input valid, next_pc, acc_a, acc_b, overflow_flag, zero_flag, halted,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/acc_cpu_front.sv
`default_nettype none

module acc_cpu_front #(
    parameter int MEM_WORDS = acc_cpu_pkg::MEM_WORDS_DEF
) (
    acc_cpu_in_if.sink           i_cmd,
    input  wire logic            i_queue_full,
    output acc_cpu_pkg::t_inst   o_push_inst,
    output logic                 o_push
);

    localparam logic [acc_cpu_pkg::LEN_W-1:0] MEM_LIMIT = acc_cpu_pkg::LEN_W'(MEM_WORDS);

    typedef logic [acc_cpu_pkg::PC_W-1:0] t_wrap_tab [256];

    // Address reduction table, built at elaboration.
    function automatic t_wrap_tab build_wrap();
        t_wrap_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = acc_cpu_pkg::PC_W'(i % MEM_WORDS);
        end
        return tab;
    endfunction

    localparam t_wrap_tab WRAP_TAB = build_wrap();

    acc_cpu_pkg::t_op_kind op_kind;

    always_comb begin
        unique case (i_cmd.command)
            acc_cpu_pkg::CMD_DEC: op_kind = acc_cpu_pkg::OP_DEC;
            acc_cpu_pkg::CMD_LDA: op_kind = acc_cpu_pkg::OP_LDA;
            acc_cpu_pkg::CMD_LDB: op_kind = acc_cpu_pkg::OP_LDB;
            acc_cpu_pkg::CMD_LDI: op_kind = acc_cpu_pkg::OP_LDI;
            acc_cpu_pkg::CMD_ST:  op_kind = acc_cpu_pkg::OP_ST;
            acc_cpu_pkg::CMD_XCH: op_kind = acc_cpu_pkg::OP_XCH;
            acc_cpu_pkg::CMD_JMP: op_kind = acc_cpu_pkg::OP_JMP;
            acc_cpu_pkg::CMD_JZS: op_kind = acc_cpu_pkg::OP_JZS;
            acc_cpu_pkg::CMD_JVS: op_kind = acc_cpu_pkg::OP_JVS;
            acc_cpu_pkg::CMD_ADD: op_kind = acc_cpu_pkg::OP_ADD;
            acc_cpu_pkg::CMD_HLT: op_kind = acc_cpu_pkg::OP_HLT;
            default:              op_kind = acc_cpu_pkg::OP_NOP;
        endcase
    end

    always_comb begin
        o_push_inst.op         = op_kind;
        o_push_inst.addr       = WRAP_TAB[i_cmd.operand[acc_cpu_pkg::PC_W-1:0]];
        o_push_inst.target     = i_cmd.operand[acc_cpu_pkg::PC_W-1:0];
        o_push_inst.tgt_in_mem = {1'b0, i_cmd.operand[acc_cpu_pkg::PC_W-1:0]} < MEM_LIMIT;
        o_push_inst.imm        = i_cmd.operand;
    end

    assign i_cmd.ready = !i_queue_full;
    assign o_push      = i_cmd.valid && !i_queue_full;

endmodule

`default_nettype wire

FILE: rtl/acc_cpu_queue.sv
`default_nettype none

module acc_cpu_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire acc_cpu_pkg::t_inst  i_push_inst,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_head_valid,
    output acc_cpu_pkg::t_inst       o_head_inst
);

    acc_cpu_pkg::t_inst                 r_slot [acc_cpu_pkg::QUEUE_DEPTH];
    logic [acc_cpu_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [acc_cpu_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [acc_cpu_pkg::QCNT_W-1:0]     r_count;

    localparam logic [acc_cpu_pkg::QCNT_W-1:0] FULL_COUNT =
        acc_cpu_pkg::QCNT_W'(acc_cpu_pkg::QUEUE_DEPTH);
    localparam logic [acc_cpu_pkg::QPTR_W-1:0] LAST_PTR =
        acc_cpu_pkg::QPTR_W'(acc_cpu_pkg::QUEUE_DEPTH - 1);

    assign o_full       = (r_count == FULL_COUNT);
    assign o_head_valid = (r_count != '0);
    assign o_head_inst  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_inst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/acc_cpu_back.sv
`default_nettype none

module acc_cpu_back #(
    parameter int MEM_WORDS = acc_cpu_pkg::MEM_WORDS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [acc_cpu_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  wire logic                            i_head_valid,
    input  wire acc_cpu_pkg::t_inst              i_head_inst,
    output logic                                 o_pop,
    acc_cpu_out_if.source                        o_res
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [acc_cpu_pkg::PC_W-1:0] PC_LAST = acc_cpu_pkg::PC_W'(MEM_WORDS - 1);

    logic [acc_cpu_pkg::WORD_W-1:0] r_mem [MEM_WORDS];

    // Architectural state; it doubles as the result payload.
    logic [acc_cpu_pkg::WORD_W-1:0] r_a, n_a;
    logic [acc_cpu_pkg::WORD_W-1:0] r_b, n_b;
    logic [acc_cpu_pkg::PC_W-1:0]   r_pc, n_pc;
    logic                           r_z, n_z;
    logic                           r_v, n_v;
    logic                           r_h, n_h;
    logic [acc_cpu_pkg::LEN_W-1:0]  r_prog_len;

    logic                           r_s1_valid;
    acc_cpu_pkg::t_inst             r_s1_inst;
    logic [acc_cpu_pkg::WORD_W-1:0] r_rd_data;
    logic                           r_out_valid;

    logic                           exec_fire;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [acc_cpu_pkg::WORD_W-1:0] wr_data;
    logic [AW-1:0]                  rd_addr;
    logic [acc_cpu_pkg::PC_W-1:0]   pc_step;
    logic [acc_cpu_pkg::WORD_W-1:0] sum;
    logic                           tgt_ok;
    logic                           take;

    assign exec_fire = r_s1_valid && (!r_out_valid || o_res.ready);
    assign o_pop     = i_head_valid && (!r_s1_valid || exec_fire);
    assign rd_addr   = i_head_inst.addr[AW-1:0];

    assign wr_en   = exec_fire && (r_s1_inst.op == acc_cpu_pkg::OP_ST ||
                                   r_s1_inst.op == acc_cpu_pkg::OP_DEC);
    assign wr_addr = (r_s1_inst.op == acc_cpu_pkg::OP_DEC) ? r_pc[AW-1:0]
                                                           : r_s1_inst.addr[AW-1:0];
    assign wr_data = (r_s1_inst.op == acc_cpu_pkg::OP_DEC) ? '0 : r_a;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // The read for the next instruction happens while the current one executes,
    // so a store to the same word in that cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_inst <= i_head_inst;
            if (wr_en && wr_addr == rd_addr) begin
                r_rd_data <= wr_data;
            end else begin
                r_rd_data <= r_mem[rd_addr];
            end
        end
    end

    assign pc_step = (r_pc == PC_LAST) ? '0 : r_pc + 1'b1;
    assign sum     = r_a + r_b;
    assign tgt_ok  = r_s1_inst.tgt_in_mem && ({1'b0, r_s1_inst.target} < r_prog_len);

    always_comb begin
        n_a  = r_a;
        n_b  = r_b;
        n_pc = pc_step;
        n_z  = r_z;
        n_v  = r_v;
        n_h  = r_h;
        take = 1'b0;
        unique case (r_s1_inst.op)
            acc_cpu_pkg::OP_DEC: ;
            acc_cpu_pkg::OP_LDA: n_a = r_rd_data;
            acc_cpu_pkg::OP_LDB: n_b = r_rd_data;
            acc_cpu_pkg::OP_LDI: n_a = r_s1_inst.imm;
            acc_cpu_pkg::OP_ST:  ;
            acc_cpu_pkg::OP_XCH: begin
                n_a = r_b;
                n_b = r_a;
            end
            acc_cpu_pkg::OP_JMP, acc_cpu_pkg::OP_JZS, acc_cpu_pkg::OP_JVS: begin
                if (r_s1_inst.op == acc_cpu_pkg::OP_JMP) begin
                    take = 1'b1;
                end else if (r_s1_inst.op == acc_cpu_pkg::OP_JZS) begin
                    take = r_z;
                end else begin
                    take = r_v;
                end
                // A bad target halts even when the branch would not be taken.
                if (!tgt_ok) begin
                    n_h  = 1'b1;
                    n_pc = r_pc;
                end else if (take) begin
                    n_pc = r_s1_inst.target;
                end
            end
            acc_cpu_pkg::OP_ADD: begin
                n_a = sum;
                n_z = (sum == '0);
                n_v = (r_a[acc_cpu_pkg::SIGN_BIT] == r_b[acc_cpu_pkg::SIGN_BIT]) &&
                      (sum[acc_cpu_pkg::SIGN_BIT] != r_a[acc_cpu_pkg::SIGN_BIT]);
            end
            acc_cpu_pkg::OP_HLT: n_h = 1'b1;
            default: n_pc = r_pc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= '0;
            r_b         <= '0;
            r_pc        <= '0;
            r_z         <= 1'b0;
            r_v         <= 1'b0;
            r_h         <= 1'b0;
            r_prog_len  <= acc_cpu_pkg::PROG_LEN_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prog_len <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (exec_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (exec_fire) begin
                r_a         <= n_a;
                r_b         <= n_b;
                r_pc        <= n_pc;
                r_z         <= n_z;
                r_v         <= n_v;
                r_h         <= n_h;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.next_pc       = r_pc;
    assign o_res.acc_a         = r_a;
    assign o_res.acc_b         = r_b;
    assign o_res.overflow_flag = r_v;
    assign o_res.zero_flag     = r_z;
    assign o_res.halted        = r_h;

endmodule

`default_nettype wire

FILE: rtl/accumulator_cpu_execute_core.sv
// A request passes the queue, the read stage and then the result registers.
// Throughput: one instruction per cycle while o_res.ready stays high; the registered
// data memory read, overlapped with the previous instruction's execution, sets this pace.
// Reset (synchronous, active low) clears A, B, pc and all flags, empties the queue
// and sets program_length to 256; the data memory is not cleared.
`default_nettype none

module accumulator_cpu_execute_core #(
    parameter int MEM_WORDS = acc_cpu_pkg::MEM_WORDS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [acc_cpu_pkg::LEN_W-1:0]   i_cfg_wdata,
    acc_cpu_in_if.sink                           i_cmd,
    acc_cpu_out_if.source                        o_res
);

    acc_cpu_pkg::t_inst push_inst;
    acc_cpu_pkg::t_inst head_inst;
    logic               push;
    logic               queue_full;
    logic               head_valid;
    logic               pop;

    acc_cpu_front #(
        .MEM_WORDS (MEM_WORDS)
    ) u_front (
        .i_cmd        (i_cmd),
        .i_queue_full (queue_full),
        .o_push_inst  (push_inst),
        .o_push       (push)
    );

    acc_cpu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_inst  (push_inst),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_inst  (head_inst)
    );

    acc_cpu_back #(
        .MEM_WORDS (MEM_WORDS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head_valid (head_valid),
        .i_head_inst  (head_inst),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

FILE: rtl/acc_cpu_chk.sv
`default_nettype none

module acc_cpu_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            i_in_ready,
    input wire logic                            i_out_valid,
    input wire logic                            i_out_ready,
    input wire logic [acc_cpu_pkg::PC_W-1:0]    i_out_pc,
    input wire logic [acc_cpu_pkg::WORD_W-1:0]  i_out_a,
    input wire logic                            i_out_halted
);

    localparam logic [2:0] MAX_IN_FLIGHT = 3'd4;

    logic       in_acc;
    logic       out_acc;
    logic [2:0] r_in_flight;
    logic       r_halt_seen;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= '0;
            r_halt_seen <= 1'b0;
        end else begin
            if (in_acc && !out_acc) begin
                r_in_flight <= r_in_flight + 1'b1;
            end else if (out_acc && !in_acc) begin
                r_in_flight <= r_in_flight - 1'b1;
            end
            if (i_out_valid && i_out_halted) begin
                r_halt_seen <= 1'b1;
            end
        end
    end

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pc) && $stable(i_out_a))
        else $error("result changed while stalled");

    // Every result belongs to a request that has not yet been answered.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_in_flight != 3'd0)
        else $error("result without an outstanding request");

    // The queue, the read stage and the result register bound the requests in flight.
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_flight <= MAX_IN_FLIGHT)
        else $error("too many requests in flight");

    // Halt stays set in every later result.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_halt_seen |-> i_out_halted)
        else $error("halt flag cleared");

endmodule

bind accumulator_cpu_execute_core acc_cpu_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_pc     (o_res.next_pc),
    .i_out_a      (o_res.acc_a),
    .i_out_halted (o_res.halted)
);

`default_nettype wire
